[hdl/rsd_pkg.sv]
// Package for the IPv6 range set difference block.
// Item types, opcodes, sequencer states and sizing constants.
// No dependencies.
`default_nettype none

package rsd_pkg;

    localparam int EXCLUDE_DEPTH = 32;
    localparam int CNT_W         = $clog2(EXCLUDE_DEPTH + 1);
    localparam int ADDR_W        = (EXCLUDE_DEPTH > 1) ? $clog2(EXCLUDE_DEPTH) : 1;
    localparam int ADDR128_W     = 128;
    localparam int ENTRY_W       = 2 * ADDR128_W;

    localparam logic [ADDR128_W-1:0] ADDR_TOP = {ADDR128_W{1'b1}};
    localparam logic [ADDR128_W-1:0] ADDR_ONE = ADDR128_W'(1);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_LOAD    = 2'd1,
        OP_PROCESS = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] range_low_upper;
        logic [63:0] range_low_lower;
        logic [63:0] range_high_upper;
        logic [63:0] range_high_lower;
    } cmd_t;

    typedef struct packed {
        logic [63:0] piece_low_upper;
        logic [63:0] piece_low_lower;
        logic [63:0] piece_high_upper;
        logic [63:0] piece_high_lower;
        logic        piece_valid;
        logic        last;
        logic        table_full;
    } res_t;

    // shared subtractor result: diff = a - b, borrow means a < b
    typedef struct packed {
        logic [ADDR128_W-1:0] diff;
        logic                 borrow;
        logic                 zero;
    } sub_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_CMP_A,
        ST_CMP_B,
        ST_CMP_D,
        ST_CMP_C,
        ST_GAP,
        ST_ADV,
        ST_FINISH,
        ST_TAIL
    } state_t;

endpackage

`default_nettype wire

[hdl/ipv6_range_set_difference.sv]
// Top level: IPv6 range set difference by sorted merge against an exclusion table.
// Depends on rsd_pkg, rsd_ram, rsd_sub.
//
//  channel   handshake                 payload
//  -------   ------------------------  -------------------------
//  command   start in, busy out        cmd    (rsd_pkg::cmd_t)
//  result    strobe out, no stall      result (rsd_pkg::res_t)
//
// Clear, load and no-op: accepted in idle, busy stays low, result the next cycle.
// Process: a range check, then per exclusion a fetch and compares; those below the
// range are skipped, one above ends it, overlaps may emit gaps; finish and tail
// emit the rest; an inverted source goes from the range check straight to finish.
// One 128-bit subtractor does one compare per cycle behind a registered-read table.
// Reset clears count, pointer and sequencer, not the table; results cannot be stalled.
`default_nettype none

module ipv6_range_set_difference (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rsd_pkg::cmd_t cmd,
    output logic               strobe,
    output rsd_pkg::res_t      result
);

    localparam int AW = rsd_pkg::ADDR128_W;

    rsd_pkg::state_t           state_reg, state_next;
    logic [rsd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [rsd_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic                      alive_reg, alive_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      cov_reg, cov_next;
    logic                      hieq_reg, hieq_next;
    logic                      strobe_reg, strobe_next;
    logic [AW-1:0]             lo_reg, lo_next;
    logic [AW-1:0]             hi_reg, hi_next;
    logic [AW-1:0]             pend_lo_reg, pend_lo_next;
    logic [AW-1:0]             pend_hi_reg, pend_hi_next;
    rsd_pkg::res_t             res_reg, res_next;

    logic                        accept;
    logic                        have_room;
    logic                        ptr_in_table;
    logic                        ram_we;
    logic                        ram_re;
    logic [rsd_pkg::ENTRY_W-1:0] ram_rdata;
    logic [AW-1:0]               elo;
    logic [AW-1:0]               ehi;
    logic                        ehi_top;
    logic [AW-1:0]               sub_a;
    logic [AW-1:0]               sub_b;
    rsd_pkg::sub_res_t           sub;

    assign busy         = (state_reg != rsd_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign have_room    = (count_reg < rsd_pkg::CNT_W'(rsd_pkg::EXCLUDE_DEPTH));
    assign ptr_in_table = (ptr_reg < count_reg)
                          && (ptr_reg < rsd_pkg::CNT_W'(rsd_pkg::EXCLUDE_DEPTH));
    assign ram_we       = accept && (cmd.op == rsd_pkg::OP_LOAD) && have_room;
    assign ram_re       = (state_reg == rsd_pkg::ST_FETCH);
    assign elo          = ram_rdata[rsd_pkg::ENTRY_W-1:AW];
    assign ehi          = ram_rdata[AW-1:0];
    assign ehi_top      = (ehi == rsd_pkg::ADDR_TOP);

    rsd_ram #(
        .WIDTH (rsd_pkg::ENTRY_W),
        .DEPTH (rsd_pkg::EXCLUDE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[rsd_pkg::ADDR_W-1:0]),
        .wdata ({cmd.range_low_upper, cmd.range_low_lower,
                 cmd.range_high_upper, cmd.range_high_lower}),
        .re    (ram_re),
        .raddr (ptr_reg[rsd_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    rsd_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub)
    );

    // operand select for the shared subtractor
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            rsd_pkg::ST_CHECK:
            begin
                sub_a = hi_reg;
                sub_b = lo_reg;
            end
            rsd_pkg::ST_CMP_A:
            begin
                sub_a = ehi;
                sub_b = lo_reg;
            end
            rsd_pkg::ST_CMP_B:
            begin
                sub_a = hi_reg;
                sub_b = elo;
            end
            rsd_pkg::ST_CMP_D:
            begin
                sub_a = ehi;
                sub_b = hi_reg;
            end
            rsd_pkg::ST_CMP_C:
            begin
                sub_a = lo_reg;
                sub_b = elo;
            end
            rsd_pkg::ST_GAP:
            begin
                sub_a = elo;
                sub_b = rsd_pkg::ADDR_ONE;
            end
            rsd_pkg::ST_ADV:
            begin
                // ehi - all ones == ehi + 1
                sub_a = ehi;
                sub_b = rsd_pkg::ADDR_TOP;
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsd_pkg::ST_IDLE:
            begin
                if (accept && (cmd.op == rsd_pkg::OP_PROCESS))
                begin
                    state_next = rsd_pkg::ST_CHECK;
                end
            end
            rsd_pkg::ST_CHECK:
            begin
                state_next = sub.borrow ? rsd_pkg::ST_FINISH : rsd_pkg::ST_FETCH;
            end
            rsd_pkg::ST_FETCH:
            begin
                state_next = ptr_in_table ? rsd_pkg::ST_CMP_A : rsd_pkg::ST_FINISH;
            end
            rsd_pkg::ST_CMP_A:
            begin
                state_next = sub.borrow ? rsd_pkg::ST_FETCH : rsd_pkg::ST_CMP_B;
            end
            rsd_pkg::ST_CMP_B:
            begin
                state_next = sub.borrow ? rsd_pkg::ST_FINISH : rsd_pkg::ST_CMP_D;
            end
            rsd_pkg::ST_CMP_D:
            begin
                state_next = rsd_pkg::ST_CMP_C;
            end
            rsd_pkg::ST_CMP_C:
            begin
                state_next = sub.borrow ? rsd_pkg::ST_GAP : rsd_pkg::ST_ADV;
            end
            rsd_pkg::ST_GAP:
            begin
                state_next = rsd_pkg::ST_ADV;
            end
            rsd_pkg::ST_ADV:
            begin
                state_next = (cov_reg || ehi_top) ? rsd_pkg::ST_FINISH : rsd_pkg::ST_FETCH;
            end
            rsd_pkg::ST_FINISH:
            begin
                state_next = (alive_reg && pend_valid_reg) ? rsd_pkg::ST_TAIL
                                                           : rsd_pkg::ST_IDLE;
            end
            rsd_pkg::ST_TAIL:
            begin
                state_next = rsd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rsd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and result outputs
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        alive_next      = alive_reg;
        pend_valid_next = pend_valid_reg;
        cov_next        = cov_reg;
        hieq_next       = hieq_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pend_lo_next    = pend_lo_reg;
        pend_hi_next    = pend_hi_reg;
        strobe_next     = 1'b0;
        res_next        = '0;
        case (state_reg)
            rsd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        rsd_pkg::OP_CLEAR:
                        begin
                            count_next    = '0;
                            ptr_next      = '0;
                            strobe_next   = 1'b1;
                            res_next.last = 1'b1;
                        end
                        rsd_pkg::OP_LOAD:
                        begin
                            if (have_room)
                            begin
                                count_next = count_reg + rsd_pkg::CNT_W'(1);
                            end
                            strobe_next         = 1'b1;
                            res_next.last       = 1'b1;
                            res_next.table_full = !have_room;
                        end
                        rsd_pkg::OP_PROCESS:
                        begin
                            lo_next         = {cmd.range_low_upper, cmd.range_low_lower};
                            hi_next         = {cmd.range_high_upper, cmd.range_high_lower};
                            alive_next      = 1'b1;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            strobe_next   = 1'b1;
                            res_next.last = 1'b1;
                        end
                    endcase
                end
            end
            rsd_pkg::ST_CHECK:
            begin
                // inverted source: empty result, pointer untouched
                if (sub.borrow)
                begin
                    alive_next = 1'b0;
                end
            end
            rsd_pkg::ST_CMP_A:
            begin
                if (sub.borrow)
                begin
                    ptr_next = ptr_reg + rsd_pkg::CNT_W'(1);
                end
            end
            rsd_pkg::ST_CMP_D:
            begin
                cov_next  = !sub.borrow;
                hieq_next = sub.zero;
            end
            rsd_pkg::ST_GAP:
            begin
                // hold the new gap back one step so the last flag is known
                if (pend_valid_reg)
                begin
                    strobe_next              = 1'b1;
                    res_next.piece_low_upper  = pend_lo_reg[AW-1:64];
                    res_next.piece_low_lower  = pend_lo_reg[63:0];
                    res_next.piece_high_upper = pend_hi_reg[AW-1:64];
                    res_next.piece_high_lower = pend_hi_reg[63:0];
                    res_next.piece_valid      = 1'b1;
                end
                pend_valid_next = 1'b1;
                pend_lo_next    = lo_reg;
                pend_hi_next    = sub.diff;
                lo_next         = elo;
            end
            rsd_pkg::ST_ADV:
            begin
                if (cov_reg)
                begin
                    alive_next = 1'b0;
                    if (hieq_reg)
                    begin
                        ptr_next = ptr_reg + rsd_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + rsd_pkg::CNT_W'(1);
                    if (ehi_top)
                    begin
                        alive_next = 1'b0;
                    end
                    else
                    begin
                        lo_next = sub.diff;
                    end
                end
            end
            rsd_pkg::ST_FINISH:
            begin
                strobe_next = 1'b1;
                if (pend_valid_reg)
                begin
                    res_next.piece_low_upper  = pend_lo_reg[AW-1:64];
                    res_next.piece_low_lower  = pend_lo_reg[63:0];
                    res_next.piece_high_upper = pend_hi_reg[AW-1:64];
                    res_next.piece_high_lower = pend_hi_reg[63:0];
                    res_next.piece_valid      = 1'b1;
                    res_next.last             = !alive_reg;
                end
                else
                begin
                    res_next.last = 1'b1;
                    if (alive_reg)
                    begin
                        res_next.piece_low_upper  = lo_reg[AW-1:64];
                        res_next.piece_low_lower  = lo_reg[63:0];
                        res_next.piece_high_upper = hi_reg[AW-1:64];
                        res_next.piece_high_lower = hi_reg[63:0];
                        res_next.piece_valid      = 1'b1;
                    end
                end
            end
            rsd_pkg::ST_TAIL:
            begin
                strobe_next               = 1'b1;
                res_next.piece_low_upper  = lo_reg[AW-1:64];
                res_next.piece_low_lower  = lo_reg[63:0];
                res_next.piece_high_upper = hi_reg[AW-1:64];
                res_next.piece_high_lower = hi_reg[63:0];
                res_next.piece_valid      = 1'b1;
                res_next.last             = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rsd_pkg::ST_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            alive_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            alive_reg      <= alive_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cov_reg     <= cov_next;
        hieq_reg    <= hieq_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pend_lo_reg <= pend_lo_next;
        pend_hi_reg <= pend_hi_next;
        res_reg     <= res_next;
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    a_ptr_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("exclusion pointer ran past the loaded count");

    a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rsd_pkg::CNT_W'(rsd_pkg::EXCLUDE_DEPTH))
        else $error("exclusion count beyond table depth");

    a_process_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == rsd_pkg::OP_PROCESS)) |=> busy)
        else $error("process item did not make the block busy");

    a_full_is_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.table_full) |-> (!result.piece_valid && result.last))
        else $error("table full flag on a piece or non-final result");

endmodule

`default_nettype wire

[hdl/rsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/rsd_sub.sv]
// Shared 128-bit subtract/compare unit: difference, borrow and zero flag.
// Depends on rsd_pkg.
`default_nettype none

module rsd_sub (
    input  wire logic [rsd_pkg::ADDR128_W-1:0] a,
    input  wire logic [rsd_pkg::ADDR128_W-1:0] b,
    output rsd_pkg::sub_res_t                  res
);

    logic [rsd_pkg::ADDR128_W:0] wide;

    assign wide       = {1'b0, a} - {1'b0, b};
    assign res.diff   = wide[rsd_pkg::ADDR128_W-1:0];
    assign res.borrow = wide[rsd_pkg::ADDR128_W];
    assign res.zero   = (wide[rsd_pkg::ADDR128_W-1:0] == '0);

endmodule

`default_nettype wire

[dv/range_diff_checker.sv]
`timescale 1ns / 1ps
// Checker for the range set difference block: watches the command and result
// channels, predicts surviving pieces per item and compares. Depends on rsd_pkg.
module range_diff_checker
    import rsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  cmd_t cmd,
    input  logic strobe,
    input  res_t result,
    output int   mismatches,
    output int   pending
);

    res_t         expected_pieces[$];
    logic [127:0] excl_lo [EXCLUDE_DEPTH];
    logic [127:0] excl_hi [EXCLUDE_DEPTH];
    int           excl_count;
    int           excl_ptr;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic res_t make_res(logic [127:0] lo, logic [127:0] hi, logic valid,
                                      logic full);
        res_t r;
        r.piece_low_upper  = lo[127:64];
        r.piece_low_lower  = lo[63:0];
        r.piece_high_upper = hi[127:64];
        r.piece_high_lower = hi[63:0];
        r.piece_valid      = valid;
        r.last             = 1'b0;
        r.table_full       = full;
        return r;
    endfunction

    function automatic void predict_pieces(cmd_t c);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] elo;
        logic [127:0] ehi;
        bit           alive;
        res_t         pieces[$];
        lo    = {c.range_low_upper, c.range_low_lower};
        hi    = {c.range_high_upper, c.range_high_lower};
        alive = 1'b1;
        case (c.op)
            OP_CLEAR:
            begin
                excl_count = 0;
                excl_ptr   = 0;
                pieces.push_back(make_res('0, '0, 1'b0, 1'b0));
            end
            OP_LOAD:
            begin
                if (excl_count < EXCLUDE_DEPTH)
                begin
                    excl_lo[excl_count] = lo;
                    excl_hi[excl_count] = hi;
                    excl_count++;
                    pieces.push_back(make_res('0, '0, 1'b0, 1'b0));
                end
                else
                begin
                    pieces.push_back(make_res('0, '0, 1'b0, 1'b1));
                end
            end
            OP_PROCESS:
            begin
                if (lo <= hi)
                begin
                    while (alive && excl_ptr < excl_count)
                    begin
                        elo = excl_lo[excl_ptr];
                        ehi = excl_hi[excl_ptr];
                        if (lo > ehi)
                        begin
                            excl_ptr++;
                            continue;
                        end
                        if (elo > hi)
                            break;
                        if (lo < elo)
                        begin
                            pieces.push_back(make_res(lo, elo - 1'b1, 1'b1, 1'b0));
                            lo = elo;
                        end
                        if (hi == ehi)
                        begin
                            excl_ptr++;
                            alive = 1'b0;
                        end
                        else if (hi < ehi)
                        begin
                            alive = 1'b0;
                        end
                        else
                        begin
                            // exclusion ending at the top address swallows the rest
                            if (ehi == ADDR_TOP)
                                alive = 1'b0;
                            else
                                lo = ehi + 1'b1;
                            excl_ptr++;
                        end
                    end
                    if (alive)
                        pieces.push_back(make_res(lo, hi, 1'b1, 1'b0));
                end
                if (pieces.size() == 0)
                    pieces.push_back(make_res('0, '0, 1'b0, 1'b0));
            end
            default:
            begin
                pieces.push_back(make_res('0, '0, 1'b0, 1'b0));
            end
        endcase
        pieces[pieces.size() - 1].last = 1'b1;
        foreach (pieces[i])
            expected_pieces.push_back(pieces[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            expected_pieces.delete();
            excl_count = 0;
            excl_ptr   = 0;
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (strobe === 1'b1)
            begin
                if (expected_pieces.size() == 0)
                begin
                    report_mismatch("result with no item pending",
                                    result.piece_low_lower, '0);
                end
                else
                begin
                    want = expected_pieces.pop_front();
                    if (result.piece_low_upper !== want.piece_low_upper)
                        report_mismatch("piece_low_upper", result.piece_low_upper,
                                        want.piece_low_upper);
                    if (result.piece_low_lower !== want.piece_low_lower)
                        report_mismatch("piece_low_lower", result.piece_low_lower,
                                        want.piece_low_lower);
                    if (result.piece_high_upper !== want.piece_high_upper)
                        report_mismatch("piece_high_upper", result.piece_high_upper,
                                        want.piece_high_upper);
                    if (result.piece_high_lower !== want.piece_high_lower)
                        report_mismatch("piece_high_lower", result.piece_high_lower,
                                        want.piece_high_lower);
                    if (result.piece_valid !== want.piece_valid)
                        report_mismatch("piece_valid", 64'(result.piece_valid),
                                        64'(want.piece_valid));
                    if (result.last !== want.last)
                        report_mismatch("last", 64'(result.last), 64'(want.last));
                    if (result.table_full !== want.table_full)
                        report_mismatch("table_full", 64'(result.table_full),
                                        64'(want.table_full));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                predict_pieces(cmd);
            pending <= expected_pieces.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the range set difference testbench: clock, reset, item stimulus and
// verdict. Depends on rsd_pkg, ipv6_range_set_difference and range_diff_checker.
module testbench;
    import rsd_pkg::*;

    localparam int           ITEM_TARGET  = 450;
    localparam int           CYCLE_LIMIT  = 600000;
    localparam int           DRAIN_CYCLES = 50;
    localparam logic [127:0] TOP_ADDR     = ADDR_TOP;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic strobe;
    cmd_t cmd;
    res_t result;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;

    logic [127:0] ex_lo [EXCLUDE_DEPTH + 3];
    logic [127:0] ex_hi [EXCLUDE_DEPTH + 3];
    int           ex_n;
    bit           idle_on;
    int           items_sent = 0;

    ipv6_range_set_difference dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    range_diff_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .strobe     (strobe),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(op_t op, logic [127:0] lo, logic [127:0] hi);
        cmd_t c;
        c.op               = op;
        c.range_low_upper  = lo[127:64];
        c.range_low_lower  = lo[63:0];
        c.range_high_upper = hi[127:64];
        c.range_high_lower = hi[63:0];
        return c;
    endfunction

    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [127:0] noisy_addr();
        case ($urandom_range(0, 3))
            0: return rand_addr();
            1: return rand_addr() >> $urandom_range(1, 127);
            2: return TOP_ADDR;
            default: return 128'($urandom_range(0, 255));
        endcase
    endfunction

    // 129-bit so callers can see a wrap past the top address
    function automatic logic [128:0] addr_step(int unsigned lo_k, int unsigned hi_k, int sh);
        logic [127:0] s;
        s = 128'($urandom_range(lo_k, hi_k)) << sh;
        return {1'b0, s};
    endfunction

    task automatic send(cmd_t c);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    // sorted, disjoint exclusions in ex_lo/ex_hi; may stop early at the top
    task automatic build_exclusions(int want, int sh);
        logic [127:0] cur;
        logic [127:0] lo;
        logic [128:0] nxt;
        bit           stop;
        ex_n = 0;
        stop = 1'b0;
        case ($urandom_range(0, 3))
            0: cur = '0;
            1: cur = rand_addr() >> $urandom_range(8, 127);
            2: cur = rand_addr();
            default: cur = TOP_ADDR - (128'($urandom_range(0, 4095)) << sh);
        endcase
        while (ex_n < want && !stop)
        begin
            nxt = {1'b0, cur} + ((ex_n == 0) ? 129'(0) : addr_step(1, 15, sh));
            if (nxt[128])
                break;
            lo  = nxt[127:0];
            nxt = {1'b0, lo} + addr_step(0, 15, sh);
            ex_lo[ex_n] = lo;
            ex_hi[ex_n] = nxt[128] ? TOP_ADDR : nxt[127:0];
            cur  = ex_hi[ex_n];
            stop = (cur == TOP_ADDR);
            ex_n++;
        end
        if (ex_n > 0 && $urandom_range(0, 5) == 0)
            ex_hi[ex_n - 1] = TOP_ADDR;
    endtask

    task automatic run_sources(int sh);
        logic [127:0] cur;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [128:0] nxt;
        logic [128:0] back;
        int           count;
        cur  = (ex_n > 0) ? ex_lo[0] : '0;
        back = addr_step(0, 15, sh);
        cur  = (cur > back[127:0]) ? cur - back[127:0] : '0;
        if ($urandom_range(0, 3) == 0)
        begin
            // one source spanning every exclusion
            send(make_cmd(OP_PROCESS, cur, TOP_ADDR));
            return;
        end
        count = $urandom_range(1, 8);
        for (int k = 0; k < count; k++)
        begin
            nxt = {1'b0, cur} + addr_step(0, 15, sh);
            if (nxt[128])
                break;
            lo  = nxt[127:0];
            nxt = {1'b0, lo} + addr_step(0, 40, sh);
            hi  = nxt[128] ? TOP_ADDR : nxt[127:0];
            if ($urandom_range(0, 9) == 0)
                send(make_cmd(OP_PROCESS, hi, lo));
            else
                send(make_cmd(OP_PROCESS, lo, hi));
            if (hi == TOP_ADDR)
                break;
            cur = hi + 1'b1;
        end
    endtask

    initial
    begin
        int sh;
        int want;
        int shifts[5];
        shifts  = '{0, 8, 60, 64, 100};
        rst_n   = 1'b0;
        start   = 1'b0;
        cmd     = '0;
        idle_on = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, inverted source, no-op, boundary crossings, top exclusion
        send(make_cmd(OP_NOP, TOP_ADDR, TOP_ADDR));
        send(make_cmd(OP_PROCESS, '0, TOP_ADDR));
        send(make_cmd(OP_PROCESS, TOP_ADDR, '0));
        send(make_cmd(OP_CLEAR, TOP_ADDR, TOP_ADDR));
        send(make_cmd(OP_LOAD, 128'h100, 128'h1ff));
        send(make_cmd(OP_LOAD, {64'h1, 64'hffff_ffff_ffff_fff0}, {64'h2, 64'h10}));
        send(make_cmd(OP_LOAD, TOP_ADDR - 128'hff, TOP_ADDR));
        send(make_cmd(OP_PROCESS, '0, 128'h150));
        send(make_cmd(OP_PROCESS, 128'h160, 128'h1ff));
        send(make_cmd(OP_PROCESS, 128'h300, {64'h3, 64'h0}));
        send(make_cmd(OP_PROCESS, {64'h4, 64'h0}, TOP_ADDR));
        send(make_cmd(OP_PROCESS, TOP_ADDR, TOP_ADDR));
        send(make_cmd(OP_PROCESS, '0, '0));
        idle_on = 1'b1;
        send(make_cmd(OP_CLEAR, '0, '0));
        send(make_cmd(OP_LOAD, '0, TOP_ADDR));
        send(make_cmd(OP_PROCESS, 128'h5, 128'ha));
        send(make_cmd(OP_PROCESS, '0, TOP_ADDR));
        send(make_cmd(OP_PROCESS, 128'h5, 128'ha));
        send(make_cmd(OP_CLEAR, '0, '0));
        send(make_cmd(OP_LOAD, '0, '0));
        send(make_cmd(OP_LOAD, TOP_ADDR, '0));
        send(make_cmd(OP_PROCESS, '0, TOP_ADDR));
        send(make_cmd(OP_NOP, '0, '0));

        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send(make_cmd(op_t'($urandom_range(0, 3)), noisy_addr(), noisy_addr()));
            end
            else
            begin
                sh   = shifts[$urandom_range(0, 4)];
                want = ($urandom_range(0, 4) == 0) ?
                       $urandom_range(EXCLUDE_DEPTH - 2, EXCLUDE_DEPTH + 2) :
                       $urandom_range(1, 8);
                send(make_cmd(OP_CLEAR, noisy_addr(), noisy_addr()));
                build_exclusions(want, sh);
                for (int i = 0; i < ex_n; i++)
                    send(make_cmd(OP_LOAD, ex_lo[i], ex_hi[i]));
                run_sources(sh);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
